FILE: rtl/rlkns_pkg.sv
// ----------------------------------------------------------------------------
// rlkns_pkg
// Shared widths, constants and types of the radius limited nearest selector.
// ----------------------------------------------------------------------------
package rlkns_pkg;

   localparam int ID_W      = 16;
   localparam int COORD_W   = 34;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int RAD_W     = 20;
   localparam int RMM_W     = 30;
   localparam int SQ_W      = 2 * RMM_W;
   localparam int DIST_W    = 62;
   localparam int RANK_W    = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = COORD_W;

   // Radius is configured in meters and compared in millimeters.
   localparam logic [RMM_W-1:0] MM_PER_M   = RMM_W'(1000);
   localparam logic [RMM_W-1:0] RMM_RESET  = RMM_W'(200000 * 1000);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] dsq;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              keep;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] dsq;
   } cand_type;

endpackage

FILE: rtl/rlkns_dist.sv
// ----------------------------------------------------------------------------
// rlkns_dist
// Three stage pipeline: coordinate differences, squares, sum and radius test.
// ----------------------------------------------------------------------------
module rlkns_dist (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [rlkns_pkg::ID_W-1:0]     in_id,
   input  logic [rlkns_pkg::COORD_W-1:0]  in_x,
   input  logic [rlkns_pkg::COORD_W-1:0]  in_y,
   input  logic [rlkns_pkg::COORD_W-1:0]  in_z,
   input  logic                           in_has_data,
   input  logic                           in_last,
   input  logic [rlkns_pkg::COORD_W-1:0]  center_x,
   input  logic [rlkns_pkg::COORD_W-1:0]  center_y,
   input  logic [rlkns_pkg::COORD_W-1:0]  center_z,
   input  logic [rlkns_pkg::RMM_W-1:0]    radius_mm,
   output rlkns_pkg::cand_type            cand
);

   localparam int DW = rlkns_pkg::DIFF_W;
   localparam int RW = rlkns_pkg::RMM_W;
   localparam int SW = rlkns_pkg::SQ_W;
   localparam int TW = rlkns_pkg::DIST_W;

   logic [DW-1:0] dx_in, dy_in, dz_in;
   logic [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic          s1_valid_ff, s1_has_ff, s1_last_ff;
   logic [rlkns_pkg::ID_W-1:0] s1_id_ff;

   logic [SW-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [SW-1:0] rr_ff;
   logic          s2_valid_ff, s2_ok_ff, s2_last_ff;
   logic [rlkns_pkg::ID_W-1:0] s2_id_ff;
   logic          far;

   logic [TW-1:0] sum;
   rlkns_pkg::cand_type cand_ff;

   function automatic logic [DW-1:0] abs_diff(input logic [rlkns_pkg::COORD_W-1:0] a,
                                               input logic [rlkns_pkg::COORD_W-1:0] b);
      logic signed [DW-1:0] d;
      d = DW'(signed'(a)) - DW'(signed'(b));
      return d[DW-1] ? DW'(-d) : DW'(d);
   endfunction

   assign dx_in = abs_diff(in_x, center_x);
   assign dy_in = abs_diff(in_y, center_y);
   assign dz_in = abs_diff(in_z, center_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      s1_id_ff  <= in_id;
      s1_has_ff <= in_has_data;
      s1_last_ff <= in_last;
   end

   // A difference at or beyond the radius rejects the site, which also
   // bounds every squared operand below the radius width.
   assign far = (dx_ff >= DW'(radius_mm)) || (dy_ff >= DW'(radius_mm)) ||
                (dz_ff >= DW'(radius_mm));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      sqx_ff     <= SW'(dx_ff[RW-1:0]) * SW'(dx_ff[RW-1:0]);
      sqy_ff     <= SW'(dy_ff[RW-1:0]) * SW'(dy_ff[RW-1:0]);
      sqz_ff     <= SW'(dz_ff[RW-1:0]) * SW'(dz_ff[RW-1:0]);
      rr_ff      <= SW'(radius_mm) * SW'(radius_mm);
      s2_ok_ff   <= s1_has_ff && !far;
      s2_last_ff <= s1_last_ff;
      s2_id_ff   <= s1_id_ff;
   end

   assign sum = TW'(sqx_ff) + TW'(sqy_ff) + TW'(sqz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else begin
         cand_ff.valid <= s2_valid_ff;
      end
      cand_ff.last <= s2_last_ff;
      cand_ff.keep <= s2_ok_ff && (sum < TW'(rr_ff));
      cand_ff.id   <= s2_id_ff;
      cand_ff.dsq  <= sum;
   end

   assign cand = cand_ff;

endmodule

FILE: rtl/rlkns_cell.sv
// ----------------------------------------------------------------------------
// rlkns_cell
// One slot of the sorted list: insert from the left, or shift from the right.
// ----------------------------------------------------------------------------
module rlkns_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  rlkns_pkg::entry_type cand,
   input  logic                 insert,
   input  logic                 shift,
   input  rlkns_pkg::entry_type left_entry,
   input  logic                 left_ahead,
   input  rlkns_pkg::entry_type right_entry,
   output rlkns_pkg::entry_type entry,
   output logic                 ahead
);

   rlkns_pkg::entry_type entry_ff, entry_in;

   // Strictly less keeps equal distances in arrival order.
   assign ahead = !entry_ff.valid || (cand.dsq < entry_ff.dsq);

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = right_entry;
      end else if (insert && ahead) begin
         entry_in = left_ahead ? left_entry : cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/rlkns_chain.sv
// ----------------------------------------------------------------------------
// rlkns_chain
// Row of list cells kept sorted nearest first; drains toward the head.
// ----------------------------------------------------------------------------
module rlkns_chain #(
   parameter int MAX_KEPT = 30
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rlkns_pkg::entry_type cand,
   input  logic                 insert,
   input  logic                 shift,
   output rlkns_pkg::entry_type head,
   output logic                 next_valid
);

   rlkns_pkg::entry_type ent [MAX_KEPT+1];
   logic [MAX_KEPT-1:0]  ahead;
   logic [MAX_KEPT-1:0]  valid_vec;

   assign ent[MAX_KEPT] = '0;

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      if (i == 0) begin : g_head
         rlkns_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cand        (cand),
            .insert      (insert),
            .shift       (shift),
            .left_entry  (cand),
            .left_ahead  (1'b0),
            .right_entry (ent[i+1]),
            .entry       (ent[i]),
            .ahead       (ahead[i])
         );
      end else begin : g_body
         rlkns_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cand        (cand),
            .insert      (insert),
            .shift       (shift),
            .left_entry  (ent[i-1]),
            .left_ahead  (ahead[i-1]),
            .right_entry (ent[i+1]),
            .entry       (ent[i]),
            .ahead       (ahead[i])
         );
      end
      assign valid_vec[i] = ent[i].valid;
   end

   assign head       = ent[0];
   assign next_valid = ent[1].valid;

   // Occupied cells always form a prefix of the row.
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + MAX_KEPT'(1))) == '0)
      else $error("list cells are not contiguous");

   a_insert_fills: assert property (@(posedge clock) disable iff (reset)
      insert && !shift |=> ent[0].valid)
      else $error("insertion left the list empty");

endmodule

FILE: rtl/radius_limited_k_nearest_select.sv
// ----------------------------------------------------------------------------
// radius_limited_k_nearest_select
// Keeps the MAX_KEPT sites nearest to a configured center within a radius.
// ----------------------------------------------------------------------------
// Sites are accepted one per cycle while the block collects. Each one
// passes the distance pipeline and, if it has data and lies inside the
// radius, is inserted into a row of MAX_KEPT cells that holds the kept
// sites sorted by squared distance, equal distances in arrival order.
// When the item flagged as set end is accepted, the input stalls while
// that item drains through the pipeline and the row is then shifted out
// one result per cycle while the output is not stalled, toward the output
// register, nearest first, or a single empty marker if nothing was kept.
// The row ends empty and the next set may start on the following cycle.
module radius_limited_k_nearest_select #(
   parameter int MAX_KEPT = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rlkns_pkg::ID_W-1:0]           req_site_id,
   input  logic [rlkns_pkg::COORD_W-1:0]        req_site_x,
   input  logic [rlkns_pkg::COORD_W-1:0]        req_site_y,
   input  logic [rlkns_pkg::COORD_W-1:0]        req_site_z,
   input  logic                                 req_has_data,
   input  logic                                 req_set_end,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rlkns_pkg::ID_W-1:0]           rsp_kept_id,
   output logic [rlkns_pkg::DIST_W-1:0]         rsp_dist_sq,
   output logic [rlkns_pkg::RANK_W-1:0]         rsp_rank,
   output logic                                 rsp_entry_valid,
   output logic                                 rsp_final_entry,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rlkns_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rlkns_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam int CW = rlkns_pkg::COORD_W;

   logic [CW-1:0]               center_x_ff, center_y_ff, center_z_ff;
   logic [rlkns_pkg::RMM_W-1:0] radius_mm_ff;

   rlkns_pkg::state_type state_ff, state_in;
   logic                 req_fire;
   logic                 slot_free;
   logic                 emit_go;
   logic                 emit_last;
   logic                 insert;

   rlkns_pkg::cand_type  cand;
   rlkns_pkg::entry_type cand_entry;
   rlkns_pkg::entry_type head;
   logic                 next_valid;

   logic [rlkns_pkg::RANK_W-1:0] rank_ff;

   logic                         rsp_valid_ff;
   logic [rlkns_pkg::ID_W-1:0]   rsp_id_ff;
   logic [rlkns_pkg::DIST_W-1:0] rsp_dist_ff;
   logic [rlkns_pkg::RANK_W-1:0] rsp_rank_ff;
   logic                         rsp_evalid_ff;
   logic                         rsp_final_ff;

   // Configuration.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         radius_mm_ff <= rlkns_pkg::RMM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rlkns_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            rlkns_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            rlkns_pkg::CSR_CENTER_Z: center_z_ff <= csr_wdata;
            rlkns_pkg::CSR_RADIUS: begin
               radius_mm_ff <= rlkns_pkg::RMM_W'(csr_wdata[rlkns_pkg::RAD_W-1:0]) *
                               rlkns_pkg::MM_PER_M;
            end
            default: ;
         endcase
      end
   end

   assign req_fire = req_valid && !req_stall;

   rlkns_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_fire),
      .in_id       (req_site_id),
      .in_x        (req_site_x),
      .in_y        (req_site_y),
      .in_z        (req_site_z),
      .in_has_data (req_has_data),
      .in_last     (req_set_end),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .center_z    (center_z_ff),
      .radius_mm   (radius_mm_ff),
      .cand        (cand)
   );

   assign cand_entry.valid = 1'b1;
   assign cand_entry.id    = cand.id;
   assign cand_entry.dsq   = cand.dsq;
   assign insert           = cand.valid && cand.keep;

   rlkns_chain #(
      .MAX_KEPT (MAX_KEPT)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .cand       (cand_entry),
      .insert     (insert),
      .shift      (emit_go),
      .head       (head),
      .next_valid (next_valid)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlkns_pkg::ST_COLLECT: begin
            if (req_fire && req_set_end) begin
               state_in = rlkns_pkg::ST_FLUSH;
            end
         end
         rlkns_pkg::ST_FLUSH: begin
            if (cand.valid && cand.last) begin
               state_in = rlkns_pkg::ST_EMIT;
            end
         end
         rlkns_pkg::ST_EMIT: begin
            if (emit_last) begin
               state_in = rlkns_pkg::ST_COLLECT;
            end
         end
         default: state_in = rlkns_pkg::ST_COLLECT;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      emit_go   = 1'b0;
      emit_last = 1'b0;
      case (state_ff)
         rlkns_pkg::ST_COLLECT: req_stall = 1'b0;
         rlkns_pkg::ST_FLUSH:   req_stall = 1'b1;
         rlkns_pkg::ST_EMIT: begin
            emit_go   = slot_free;
            emit_last = slot_free && (!head.valid || !next_valid);
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlkns_pkg::ST_COLLECT;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (emit_last) begin
            rank_ff <= '0;
         end else if (emit_go) begin
            rank_ff <= rank_ff + rlkns_pkg::RANK_W'(1);
         end
      end
   end

   // Output register. An empty head at the first emit cycle is the marker.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_id_ff     <= head.valid ? head.id : '0;
         rsp_dist_ff   <= head.valid ? head.dsq : '0;
         rsp_rank_ff   <= head.valid ? rank_ff : '0;
         rsp_evalid_ff <= head.valid;
         rsp_final_ff  <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_id     = rsp_id_ff;
   assign rsp_dist_sq     = rsp_dist_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_entry_valid = rsp_evalid_ff;
   assign rsp_final_entry = rsp_final_ff;

   a_marker_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_final_entry)
      else $error("empty marker item not flagged as final");

   a_no_insert_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlkns_pkg::ST_EMIT |-> !cand.valid)
      else $error("site reached the list while it was being emitted");

   a_cleared: assert property (@(posedge clock) disable iff (reset)
      emit_last |=> !head.valid)
      else $error("list not empty after the final item");

endmodule

FILE: bench/radius_limited_k_nearest_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radius_limited_k_nearest_select_tb
// Self-checking bench for the radius limited nearest site selector.
// ----------------------------------------------------------------------------
// Sites are fed through the request channel from a queue and every accepted
// site is run through a local distance and sorted-list predictor. The lists
// that come out on the response channel are checked field by field against
// the predicted ones. Both channels idle and stall at random. The center and
// radius registers are reprogrammed between sets while the block is idle,
// covering the coordinate extremes, a zero radius and radii up to 1e6 m.
// ----------------------------------------------------------------------------
module radius_limited_k_nearest_select_tb;

   localparam int     ID_W        = rlkns_pkg::ID_W;
   localparam int     COORD_W     = rlkns_pkg::COORD_W;
   localparam int     RAD_W       = rlkns_pkg::RAD_W;
   localparam int     DIST_W      = rlkns_pkg::DIST_W;
   localparam int     RANK_W      = rlkns_pkg::RANK_W;
   localparam int     CSR_IDX_W   = rlkns_pkg::CSR_IDX_W;
   localparam int     CSR_DAT_W   = rlkns_pkg::CSR_DAT_W;

   localparam int     MAX_KEPT    = 30;
   localparam int     QUIET_LIMIT = 1000;
   localparam longint COORD_LIM   = 64'sd8589934591;
   localparam longint BIG         = 2 * COORD_LIM;

   localparam logic [COORD_W-1:0] FAR_POS = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] FAR_NEG = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};

   typedef struct {
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               has_data;
      logic               set_end;
   } site_type;

   typedef struct {
      logic [ID_W-1:0]   kept_id;
      logic [DIST_W-1:0] dist_sq;
      logic [RANK_W-1:0] rank;
      logic              entry_valid;
      logic              final_entry;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [ID_W-1:0]      req_site_id  = '0;
   logic [COORD_W-1:0]   req_site_x   = '0;
   logic [COORD_W-1:0]   req_site_y   = '0;
   logic [COORD_W-1:0]   req_site_z   = '0;
   logic                 req_has_data = 1'b0;
   logic                 req_set_end  = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   logic [ID_W-1:0]      rsp_kept_id;
   logic [DIST_W-1:0]    rsp_dist_sq;
   logic [RANK_W-1:0]    rsp_rank;
   logic                 rsp_entry_valid;
   logic                 rsp_final_entry;

   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   // Register copies, starting from their reset values.
   logic [COORD_W-1:0] ctr_x = '0;
   logic [COORD_W-1:0] ctr_y = '0;
   logic [COORD_W-1:0] ctr_z = '0;
   logic [RAD_W-1:0]   rad_m = RAD_W'(200000);

   logic [ID_W-1:0]   near_id   [MAX_KEPT];
   logic [DIST_W-1:0] near_dist [MAX_KEPT];
   int                near_count = 0;

   site_type sites_to_send[$];
   pick_type picks_due[$];
   site_type site_on_bus;

   int sites_queued   = 0;
   int sites_accepted = 0;
   int sets_closed    = 0;
   int full_lists     = 0;
   int results_seen   = 0;
   int markers_seen   = 0;
   int settings_used  = 1;
   int mismatches     = 0;
   int quiet_cycles   = 0;
   int req_gap        = 0;
   int rsp_hold       = 0;
   bit req_calm       = 1'b0;
   bit rsp_calm       = 1'b0;

   radius_limited_k_nearest_select #(
      .MAX_KEPT (MAX_KEPT)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_site_id     (req_site_id),
      .req_site_x      (req_site_x),
      .req_site_y      (req_site_y),
      .req_site_z      (req_site_z),
      .req_has_data    (req_has_data),
      .req_set_end     (req_set_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept_id     (rsp_kept_id),
      .rsp_dist_sq     (rsp_dist_sq),
      .rsp_rank        (rsp_rank),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_final_entry (rsp_final_entry),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic longint unsigned coord_mag(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return (d < 0) ? -d : d;
   endfunction

   // Applies one accepted site to the kept list and, at a set end, queues
   // the list that the block has to emit.
   function automatic void rank_site(site_type s);
      longint unsigned r, dx, dy, dz, d;
      int pos, i;
      pick_type p;
      r  = rad_m * 64'd1000;
      dx = coord_mag(s.x, ctr_x);
      dy = coord_mag(s.y, ctr_y);
      dz = coord_mag(s.z, ctr_z);
      // Oversized differences are dropped first, so the squares cannot overflow.
      if (s.has_data && dx < r && dy < r && dz < r) begin
         d = dx * dx + dy * dy + dz * dz;
         if (d < r * r) begin
            pos = 0;
            while (pos < near_count && near_dist[pos] <= d)
               pos++;
            if (pos < MAX_KEPT) begin
               i = (near_count < MAX_KEPT) ? near_count : MAX_KEPT - 1;
               while (i > pos) begin
                  near_id[i]   = near_id[i-1];
                  near_dist[i] = near_dist[i-1];
                  i--;
               end
               near_id[pos]   = s.id;
               near_dist[pos] = DIST_W'(d);
               if (near_count < MAX_KEPT)
                  near_count++;
            end
         end
      end
      if (s.set_end) begin
         sets_closed++;
         if (near_count == MAX_KEPT)
            full_lists++;
         if (near_count == 0) begin
            p = '{kept_id: '0, dist_sq: '0, rank: '0, entry_valid: 1'b0, final_entry: 1'b1};
            picks_due.insert(picks_due.size(), p);
         end
         for (int k = 0; k < near_count; k++) begin
            p.kept_id     = near_id[k];
            p.dist_sq     = near_dist[k];
            p.rank        = RANK_W'(k);
            p.entry_valid = 1'b1;
            p.final_entry = (k == near_count - 1);
            picks_due.insert(picks_due.size(), p);
         end
         near_count = 0;
      end
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(longint v);
      if (v > COORD_LIM)
         v = COORD_LIM;
      else if (v < -COORD_LIM)
         v = -COORD_LIM;
      return COORD_W'(v);
   endfunction

   // Any 34-bit value except the most negative one, which lies outside the range.
   function automatic logic [COORD_W-1:0] wide_coord();
      logic [COORD_W-1:0] w;
      w = COORD_W'({$urandom, $urandom});
      if (w == {1'b1, {(COORD_W-1){1'b0}}})
         w[0] = 1'b1;
      return w;
   endfunction

   // Mostly inside the sphere, some just outside, a few anywhere at all.
   function automatic longint near_off(longint r);
      longint span;
      int unsigned roll;
      roll = $urandom_range(0, 9);
      span = (r == 0) ? 1000 : r;
      if (roll == 9)
         return longint'($signed(wide_coord()));
      span = (roll < 7) ? span * 11 / 20 : span * 6 / 5;
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   task automatic put_site(longint ox, longint oy, longint oz, bit has, bit last, int id);
      site_type s;
      s.id       = ID_W'(id);
      s.x        = clamp_coord(longint'($signed(ctr_x)) + ox);
      s.y        = clamp_coord(longint'($signed(ctr_y)) + oy);
      s.z        = clamp_coord(longint'($signed(ctr_z)) + oz);
      s.has_data = has;
      s.set_end  = last;
      sites_to_send.insert(sites_to_send.size(), s);
      sites_queued++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rlkns_pkg::CSR_CENTER_X: ctr_x = val;
         rlkns_pkg::CSR_CENTER_Y: ctr_y = val;
         rlkns_pkg::CSR_CENTER_Z: ctr_z = val;
         rlkns_pkg::CSR_RADIUS:   rad_m = val[RAD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [COORD_W-1:0] cz, logic [RAD_W-1:0] rad);
      write_reg(rlkns_pkg::CSR_CENTER_X, cx);
      write_reg(rlkns_pkg::CSR_CENTER_Y, cy);
      write_reg(rlkns_pkg::CSR_CENTER_Z, cz);
      write_reg(rlkns_pkg::CSR_RADIUS, CSR_DAT_W'(rad));
      settings_used++;
   endtask

   // Waits until every queued site is in and every list has come out, then
   // lets the distance pipeline run empty.
   task automatic settle();
      while (sites_accepted != sites_queued || picks_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_random_sets(int budget);
      int n, size;
      bit first;
      longint r, ox, oy, oz, swap;
      n     = 0;
      first = 1'b1;
      r     = rad_m * 64'd1000;
      ox    = 0;
      oy    = 0;
      oz    = 0;
      while (n < budget) begin
         // Each phase opens with a set long enough to overflow the list, budget permitting.
         if (first || $urandom_range(0, 5) == 0)
            size = $urandom_range(31, 38);
         else if ($urandom_range(0, 7) == 0)
            size = 1;
         else
            size = $urandom_range(2, 12);
         first = 1'b0;
         if (size > budget - n)
            size = budget - n;
         for (int k = 0; k < size; k++) begin
            if (k > 0 && $urandom_range(0, 5) == 0) begin
               // A rotation of the previous offset gives an equal distance.
               swap = ox;
               ox   = oy;
               oy   = -swap;
            end else begin
               ox = near_off(r);
               oy = near_off(r);
               oz = near_off(r);
            end
            put_site(ox, oy, oz, $urandom_range(0, 7) != 0, k == size - 1,
                     $urandom_range(0, 65535));
         end
         n += size;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            rank_site(site_on_bus);
            sites_accepted++;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sites_to_send.size() != 0) begin
            site_on_bus = sites_to_send.pop_front();
            req_site_id  <= site_on_bus.id;
            req_site_x   <= site_on_bus.x;
            req_site_y   <= site_on_bus.y;
            req_site_z   <= site_on_bus.z;
            req_has_data <= site_on_bus.has_data;
            req_set_end  <= site_on_bus.set_end;
            req_valid    <= 1'b1;
            if ($urandom_range(0, 15) == 0)
               req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      pick_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (picks_due.size() == 0) begin
               report($sformatf("result with id %0h arrived with nothing pending",
                                rsp_kept_id));
            end else begin
               want = picks_due.pop_front();
               if (rsp_kept_id !== want.kept_id)
                  report($sformatf("result %0d kept_id: expected %0h, got %0h",
                                   results_seen, want.kept_id, rsp_kept_id));
               if (rsp_dist_sq !== want.dist_sq)
                  report($sformatf("result %0d dist_sq: expected %0h, got %0h",
                                   results_seen, want.dist_sq, rsp_dist_sq));
               if (rsp_rank !== want.rank)
                  report($sformatf("result %0d rank: expected %0d, got %0d",
                                   results_seen, want.rank, rsp_rank));
               if (rsp_entry_valid !== want.entry_valid)
                  report($sformatf("result %0d entry_valid: expected %0b, got %0b",
                                   results_seen, want.entry_valid, rsp_entry_valid));
               if (rsp_final_entry !== want.final_entry)
                  report($sformatf("result %0d final_entry: expected %0b, got %0b",
                                   results_seen, want.final_entry, rsp_final_entry));
               if (!want.entry_valid)
                  markers_seen++;
            end
            results_seen++;
            if ($urandom_range(0, 15) == 0)
               rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 8);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results still pending",
                  $time, QUIET_LIMIT, picks_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: center at the origin, radius of 2e8 mm.
      put_site(0, 0, 0, 1, 0, 0);
      put_site(BIG, 0, 0, 1, 0, 65535);
      put_site(-BIG, -BIG, -BIG, 1, 0, 1);
      put_site(5, 5, 5, 0, 0, 2);
      put_site(200000000, 0, 0, 1, 0, 3);
      put_site(0, -199999999, 0, 1, 0, 4);
      // A 3-4-5 triangle lands exactly on the sphere and must be dropped.
      put_site(120000000, 160000000, 0, 1, 0, 5);
      put_site(120000000, 159999999, 0, 1, 0, 6);
      put_site(0, 0, -1000, 1, 0, 7);
      put_site(1000, 0, 0, 1, 1, 8);
      put_site(0, 0, 0, 0, 1, 9);
      put_site(0, 5, 0, 1, 0, 10);
      put_site(BIG, BIG, BIG, 1, 1, 11);
      put_site(-5, 0, 0, 1, 1, 12);
      settle();

      apply_setting('0, '0, '0, '0);
      put_site(0, 0, 0, 1, 0, 13);
      put_site(0, 0, 0, 1, 1, 14);
      settle();

      apply_setting(COORD_W'(64'sd123456789), COORD_W'(-64'sd987654321),
                    COORD_W'(64'sd4242), RAD_W'(1000000));
      queue_random_sets(60);
      settle();

      apply_setting(FAR_POS, FAR_POS, FAR_POS, RAD_W'(1));
      queue_random_sets(55);
      settle();

      apply_setting(FAR_NEG, FAR_NEG, FAR_NEG, RAD_W'(524288));
      queue_random_sets(55);
      settle();

      apply_setting(wide_coord(), wide_coord(), wide_coord(), '0);
      queue_random_sets(20);
      settle();

      apply_setting(wide_coord(), wide_coord(), wide_coord(),
                    RAD_W'($urandom_range(0, 1000000)));
      queue_random_sets(65);
      settle();

      apply_setting('0, '0, '0, RAD_W'(200000));
      queue_random_sets(65);
      settle();

      $display("Run covered %0d sites in %0d sets under %0d register settings.",
               sites_accepted, sets_closed, settings_used);
      $display("%0d results checked: %0d empty markers, %0d lists filled to capacity.",
               results_seen, markers_seen, full_lists);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
rtl/rlkns_pkg.sv
rtl/rlkns_dist.sv
rtl/rlkns_cell.sv
rtl/rlkns_chain.sv
rtl/radius_limited_k_nearest_select.sv
bench/radius_limited_k_nearest_select_tb.sv
